>>> rtl/core/mlpbp_pkg.sv
`timescale 1ns / 1ps

package mlpbp_pkg;

    localparam int VAL_W         = 16;  // Q4.12 data values
    localparam int ACT_W         = 13;  // sigmoid activation, 0..4096
    localparam int DER_W         = 11;  // s(1-s), 0..1024
    localparam int SCL_W         = 21;  // floor(lr * x / 4096)
    localparam int CNT_W         = 7;   // sequencer index, covers up to 127 hidden units
    localparam int FEATURE_COUNT = 9;
    localparam int MAX_INPUTS    = 10;
    localparam int TDATA_IN_W    = 160;
    localparam int TDATA_OUT_W   = 40;
    localparam int POS_W         = 8;

    localparam logic [VAL_W-1:0] RATE_RESET = 16'd4096;
    localparam logic [ACT_W-1:0] ONE_Q12    = 13'd4096;

    typedef enum logic [1:0] {
        CMD_INFER = 2'd0,
        CMD_TRAIN = 2'd1,
        CMD_LOAD  = 2'd2,
        CMD_SPARE = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLR,
        OP_MAC,
        OP_SIG,
        OP_DER,
        OP_GO,
        OP_GH1,
        OP_GH2,
        OP_UPDV,
        OP_UPDW
    } seq_op_t;

    typedef struct packed {
        seq_op_t          op;
        logic [CNT_W-1:0] idx;
    } seq_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FWD,
        ST_HSIG,
        ST_OMAC,
        ST_OSIG,
        ST_ODER,
        ST_GO,
        ST_GH1,
        ST_GH2,
        ST_UPDV,
        ST_UPDW,
        ST_RESP
    } state_t;

    localparam logic [ACT_W-1:0] SIG_TABLE [0:32] = '{
        13'd1,    13'd2,    13'd4,    13'd6,    13'd10,   13'd17,   13'd27,   13'd45,
        13'd74,   13'd120,  13'd194,  13'd311,  13'd488,  13'd747,  13'd1102, 13'd1546,
        13'd2048,
        13'd2550, 13'd2994, 13'd3349, 13'd3608, 13'd3785, 13'd3902, 13'd3976, 13'd4022,
        13'd4051, 13'd4069, 13'd4079, 13'd4086, 13'd4090, 13'd4092, 13'd4094, 13'd4095
    };

    // table segment from the top five bits of net + 32768, interpolate on the rest
    function automatic logic [ACT_W-1:0] sig_lookup(input logic signed [VAL_W-1:0] net);
        logic [VAL_W-1:0] u;
        logic [5:0]       i;
        logic [5:0]       i1;
        logic [ACT_W-1:0] lo;
        logic [ACT_W-1:0] diff;
        logic [23:0]      prod;
        u    = {~net[VAL_W-1], net[VAL_W-2:0]};
        i    = {1'b0, u[15:11]};
        i1   = i + 6'd1;
        lo   = SIG_TABLE[i];
        diff = SIG_TABLE[i1] - lo;
        prod = {11'd0, diff} * {13'd0, u[10:0]};
        return lo + prod[23:11];
    endfunction

    function automatic logic [DER_W-1:0] deriv(input logic [ACT_W-1:0] s);
        logic [25:0] p;
        p = {13'd0, s} * {13'd0, ONE_Q12 - s};
        return p[22:12];
    endfunction

endpackage

>>> rtl/core/mlpbp_lane.sv
`timescale 1ns / 1ps

module mlpbp_lane import mlpbp_pkg::*; #(
    parameter int INPUT_COUNT  = 9,
    parameter int WEIGHT_WIDTH = 16
) (
    input  logic                           aclk,
    input  seq_ctrl_t                      ctrl,
    input  logic signed [VAL_W-1:0]        x_in,
    input  logic signed [VAL_W-1:0]        go_in,
    input  logic [VAL_W-1:0]               lrate,
    input  logic signed [SCL_W-1:0]        scaled_in,
    input  logic                           ld_we,
    input  logic                           ld_v,
    input  logic [CNT_W-1:0]               ld_idx,
    input  logic signed [WEIGHT_WIDTH-1:0] ld_data,
    output logic [ACT_W-1:0]               h_out,
    output logic signed [WEIGHT_WIDTH-1:0] v_out
);

    localparam int WW = WEIGHT_WIDTH;
    localparam int IW = $clog2(INPUT_COUNT + 1);
    localparam int AW = WW + 20;
    localparam int GW = WW + 4;
    localparam int SW = WW + 22;

    logic signed [WW-1:0]    w_reg [INPUT_COUNT+1];
    logic signed [WW-1:0]    v_reg;
    logic signed [AW-1:0]    acc_reg;
    logic [ACT_W-1:0]        h_reg;
    logic [DER_W-1:0]        dh_reg;
    logic [VAL_W-1:0]        lrh_reg;
    logic signed [GW-1:0]    t1_reg;
    logic signed [GW-1:0]    gh_reg;

    logic signed [WW-1:0]    w_rd;
    logic signed [WW+15:0]   mac_prod;
    logic signed [VAL_W-1:0] net;
    logic signed [WW+15:0]   t1_full;
    logic signed [WW+15:0]   gh_full;
    logic signed [32:0]      vstep_full;
    logic signed [WW+24:0]   wstep_full;
    logic signed [SW-1:0]    v_sum;
    logic signed [SW-1:0]    w_sum;
    logic [28:0]             lrh_full;

    function automatic logic signed [WW-1:0] sat_w(input logic signed [SW-1:0] v);
        if (!v[SW-1] && (|v[SW-2:WW-1])) begin
            return {1'b0, {(WW-1){1'b1}}};
        end else if (v[SW-1] && !(&v[SW-2:WW-1])) begin
            return {1'b1, {(WW-1){1'b0}}};
        end
        return v[WW-1:0];
    endfunction

    always_comb begin
        w_rd       = w_reg[ctrl.idx[IW-1:0]];
        mac_prod   = x_in * w_rd;
        if (!acc_reg[AW-1] && (|acc_reg[AW-2:27])) begin
            net = 16'sh7FFF;
        end else if (acc_reg[AW-1] && !(&acc_reg[AW-2:27])) begin
            net = -16'sh8000;
        end else begin
            net = acc_reg[27:12];
        end
        t1_full    = v_reg * go_in;
        gh_full    = t1_reg * $signed({1'b0, dh_reg});
        lrh_full   = {13'd0, lrate} * {16'd0, h_reg};
        vstep_full = $signed({1'b0, lrh_reg}) * go_in;
        wstep_full = scaled_in * gh_reg;
        v_sum      = SW'(v_reg) + SW'($signed(vstep_full[32:12]));
        w_sum      = SW'(w_rd) + SW'($signed(wstep_full[WW+24:12]));
    end

    always_ff @(posedge aclk) begin
        if (ld_we) begin
            if (ld_v) begin
                v_reg <= ld_data;
            end else begin
                w_reg[ld_idx[IW-1:0]] <= ld_data;
            end
        end
        case (ctrl.op)
            OP_CLR:  acc_reg <= '0;
            OP_MAC:  acc_reg <= acc_reg + AW'(mac_prod);
            OP_SIG:  h_reg   <= sig_lookup(net);
            OP_GH1: begin
                t1_reg  <= t1_full[WW+15:12];
                dh_reg  <= deriv(h_reg);
                lrh_reg <= lrh_full[27:12];
            end
            OP_GH2:  gh_reg  <= gh_full[WW+15:12];
            OP_UPDV: v_reg   <= sat_w(v_sum);
            OP_UPDW: w_reg[ctrl.idx[IW-1:0]] <= sat_w(w_sum);
            default: ;
        endcase
    end

    assign h_out = h_reg;
    assign v_out = v_reg;

endmodule

>>> rtl/core/mlpbp_merge.sv
`timescale 1ns / 1ps

module mlpbp_merge import mlpbp_pkg::*; #(
    parameter int HIDDEN_COUNT = 18,
    parameter int WEIGHT_WIDTH = 16
) (
    input  logic                                   aclk,
    input  seq_ctrl_t                              ctrl,
    input  logic [HIDDEN_COUNT*ACT_W-1:0]          h_all,
    input  logic [HIDDEN_COUNT*WEIGHT_WIDTH-1:0]   v_all,
    input  logic signed [VAL_W-1:0]                target,
    input  logic [VAL_W-1:0]                       lrate,
    input  logic                                   ld_we,
    input  logic signed [WEIGHT_WIDTH-1:0]         ld_data,
    output logic [ACT_W-1:0]                       o_out,
    output logic signed [VAL_W-1:0]                err_out,
    output logic signed [VAL_W-1:0]                go_out
);

    localparam int WW = WEIGHT_WIDTH;
    localparam int JW = $clog2(HIDDEN_COUNT + 1);
    localparam int MW = WW + 21;
    localparam int SW = WW + 22;

    logic signed [WW-1:0]    vb_reg;
    logic signed [MW-1:0]    acc_reg;
    logic [ACT_W-1:0]        o_reg;
    logic [DER_W-1:0]        do_reg;
    logic signed [VAL_W-1:0] err_reg;
    logic signed [VAL_W-1:0] go_reg;

    logic [ACT_W-1:0]        h_ext [HIDDEN_COUNT+1];
    logic signed [WW-1:0]    v_ext [HIDDEN_COUNT+1];
    logic [ACT_W-1:0]        h_sel;
    logic signed [WW-1:0]    v_sel;
    logic signed [WW+13:0]   mac_prod;
    logic signed [VAL_W-1:0] net;
    logic [ACT_W-1:0]        o_next;
    logic signed [17:0]      diff;
    logic signed [VAL_W-1:0] err_next;
    logic signed [27:0]      go_full;
    logic signed [32:0]      bstep_full;
    logic signed [SW-1:0]    b_sum;
    logic signed [WW-1:0]    b_sat;

    always_comb begin
        for (int j = 0; j < HIDDEN_COUNT; j++) begin
            h_ext[j] = h_all[j*ACT_W +: ACT_W];
            v_ext[j] = v_all[j*WW +: WW];
        end
        h_ext[HIDDEN_COUNT] = ONE_Q12;
        v_ext[HIDDEN_COUNT] = vb_reg;
        h_sel    = h_ext[ctrl.idx[JW-1:0]];
        v_sel    = v_ext[ctrl.idx[JW-1:0]];
        mac_prod = $signed({1'b0, h_sel}) * v_sel;

        if (!acc_reg[MW-1] && (|acc_reg[MW-2:27])) begin
            net = 16'sh7FFF;
        end else if (acc_reg[MW-1] && !(&acc_reg[MW-2:27])) begin
            net = -16'sh8000;
        end else begin
            net = acc_reg[27:12];
        end
        o_next = sig_lookup(net);
        diff   = $signed({{2{target[VAL_W-1]}}, target}) - $signed({5'd0, o_next});
        if (!diff[17] && (|diff[16:15])) begin
            err_next = 16'sh7FFF;
        end else if (diff[17] && !(&diff[16:15])) begin
            err_next = -16'sh8000;
        end else begin
            err_next = diff[15:0];
        end

        go_full    = err_reg * $signed({1'b0, do_reg});
        bstep_full = $signed({1'b0, lrate}) * go_reg;
        b_sum      = SW'(vb_reg) + SW'($signed(bstep_full[32:12]));
        if (!b_sum[SW-1] && (|b_sum[SW-2:WW-1])) begin
            b_sat = {1'b0, {(WW-1){1'b1}}};
        end else if (b_sum[SW-1] && !(&b_sum[SW-2:WW-1])) begin
            b_sat = {1'b1, {(WW-1){1'b0}}};
        end else begin
            b_sat = b_sum[WW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_we) begin
            vb_reg <= ld_data;
        end
        case (ctrl.op)
            OP_CLR: acc_reg <= '0;
            OP_MAC: acc_reg <= acc_reg + MW'(mac_prod);
            OP_SIG: begin
                o_reg   <= o_next;
                err_reg <= err_next;
            end
            OP_DER:  do_reg <= deriv(o_reg);
            OP_GO:   go_reg <= go_full[27:12];
            OP_UPDV: vb_reg <= b_sat;
            default: ;
        endcase
    end

    assign o_out   = o_reg;
    assign err_out = err_reg;
    assign go_out  = go_reg;

endmodule

>>> rtl/core/mlp_backprop_trainer.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// s_       in         s_tvalid/s_tready    tuser: command; tdata: feature_0..8, target
// m_       out        m_tvalid/m_tready    tdata: net_output, output_error, load_position
// cfg_     in         cfg_valid/cfg_ready  cfg_data: learning_rate
//
// One item at a time. A load goes straight to the response. Infer runs the per-lane input
// MAC followed by the output-unit MAC over all hidden lanes.
// Train adds the gradients and per-input weight updates.
// Reset clears the sequencer, the load pointer and the learning rate (1.0); weights hold
// no reset value. A stalled result waits in the output register; a new item is taken
// once the result is registered.

module mlp_backprop_trainer import mlpbp_pkg::*; #(
    parameter int INPUT_COUNT  = 9,
    parameter int HIDDEN_COUNT = 18,
    parameter int WEIGHT_WIDTH = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [TDATA_IN_W-1:0]   s_tdata,   // feature_0 .. feature_8, target
    input  logic [1:0]              s_tuser,   // command
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [TDATA_OUT_W-1:0]  m_tdata,   // net_output, output_error, load_position, pad
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [VAL_W-1:0]        cfg_data
);

    localparam int WW     = WEIGHT_WIDTH;
    localparam int XW     = $clog2(INPUT_COUNT + 1);
    localparam int LIW    = $clog2(INPUT_COUNT + 2);
    localparam int JW     = $clog2(HIDDEN_COUNT + 1);
    localparam int TOTAL  = (INPUT_COUNT + 1) * HIDDEN_COUNT + HIDDEN_COUNT + 1;
    localparam int PW     = $clog2(TOTAL + 1);

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        widx_reg;
    logic signed [VAL_W-1:0] x_reg [INPUT_COUNT+1];
    logic signed [VAL_W-1:0] tgt_reg;
    logic                    train_reg;
    logic                    res_load_reg;
    logic signed [SCL_W-1:0] scaled_reg;
    logic [VAL_W-1:0]        lr_reg;
    logic [PW-1:0]           ptr_reg;
    logic [LIW-1:0]          ld_i_reg;
    logic [JW-1:0]           ld_j_reg;
    logic                    m_valid_reg;
    logic [ACT_W-1:0]        m_net_reg;
    logic [VAL_W-1:0]        m_err_reg;
    logic [POS_W-1:0]        m_pos_reg;

    seq_ctrl_t               lane_ctrl;
    seq_ctrl_t               merge_ctrl;
    logic                    accept;
    logic                    out_load;
    cmd_t                    cmd;
    logic [VAL_W*MAX_INPUTS-1:0] feat_ext;
    logic signed [VAL_W-1:0] s_target;
    logic signed [VAL_W-1:0] x_sel;
    logic signed [32:0]      scale_full;
    logic signed [32:0]      tgt_ext;
    logic signed [WW-1:0]    ld_data;
    logic                    ld_go;
    logic                    in_ho;
    logic [HIDDEN_COUNT-1:0] lane_we;
    logic                    bias_we;
    logic [HIDDEN_COUNT*ACT_W-1:0] h_all;
    logic [HIDDEN_COUNT*WW-1:0]    v_all;
    logic [ACT_W-1:0]        o_w;
    logic signed [VAL_W-1:0] err_w;
    logic signed [VAL_W-1:0] go_w;

    assign cmd       = cmd_t'(s_tuser);
    assign accept    = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;
    assign feat_ext  = {{(VAL_W*(MAX_INPUTS-FEATURE_COUNT)){1'b0}},
                        s_tdata[VAL_W*FEATURE_COUNT-1:0]};
    assign s_target  = s_tdata[VAL_W*FEATURE_COUNT +: VAL_W];

    always_comb begin
        if (cnt_reg <= CNT_W'(INPUT_COUNT)) begin
            x_sel = x_reg[cnt_reg[XW-1:0]];
        end else begin
            x_sel = '0;
        end
        scale_full = $signed({1'b0, lr_reg}) * x_sel;
    end

    // load: saturate the target to the weight width
    always_comb begin
        tgt_ext = 33'(s_target);
        if (!tgt_ext[32] && (|tgt_ext[31:WW-1])) begin
            ld_data = {1'b0, {(WW-1){1'b1}}};
        end else if (tgt_ext[32] && !(&tgt_ext[31:WW-1])) begin
            ld_data = {1'b1, {(WW-1){1'b0}}};
        end else begin
            ld_data = tgt_ext[WW-1:0];
        end
        ld_go   = accept && (cmd == CMD_LOAD) && (ptr_reg != PW'(TOTAL));
        in_ho   = (ld_i_reg == LIW'(INPUT_COUNT + 1));
        bias_we = ld_go && in_ho && (ld_j_reg == JW'(HIDDEN_COUNT));
        for (int j = 0; j < HIDDEN_COUNT; j++) begin
            lane_we[j] = ld_go && (ld_j_reg == JW'(j));
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (cmd == CMD_LOAD) ? ST_RESP : ST_FWD;
                end
            end
            ST_FWD:  if (cnt_reg == CNT_W'(INPUT_COUNT)) state_next = ST_HSIG;
            ST_HSIG: state_next = ST_OMAC;
            ST_OMAC: if (cnt_reg == CNT_W'(HIDDEN_COUNT)) state_next = ST_OSIG;
            ST_OSIG: state_next = train_reg ? ST_ODER : ST_RESP;
            ST_ODER: state_next = ST_GO;
            ST_GO:   state_next = ST_GH1;
            ST_GH1:  state_next = ST_GH2;
            ST_GH2:  state_next = ST_UPDV;
            ST_UPDV: state_next = ST_UPDW;
            ST_UPDW: if (widx_reg == CNT_W'(INPUT_COUNT)) state_next = ST_RESP;
            ST_RESP: if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        lane_ctrl  = '{op: OP_NOP, idx: '0};
        merge_ctrl = '{op: OP_NOP, idx: '0};
        s_tready   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (accept && cmd != CMD_LOAD) begin
                    lane_ctrl.op  = OP_CLR;
                    merge_ctrl.op = OP_CLR;
                end
            end
            ST_FWD:  lane_ctrl  = '{op: OP_MAC, idx: cnt_reg};
            ST_HSIG: lane_ctrl.op = OP_SIG;
            ST_OMAC: merge_ctrl = '{op: OP_MAC, idx: cnt_reg};
            ST_OSIG: merge_ctrl.op = OP_SIG;
            ST_ODER: merge_ctrl.op = OP_DER;
            ST_GO:   merge_ctrl.op = OP_GO;
            ST_GH1:  lane_ctrl.op = OP_GH1;
            ST_GH2:  lane_ctrl.op = OP_GH2;
            ST_UPDV: begin
                lane_ctrl.op  = OP_UPDV;
                merge_ctrl.op = OP_UPDV;
            end
            ST_UPDW: lane_ctrl = '{op: OP_UPDW, idx: widx_reg};
            ST_RESP: out_load = !m_valid_reg || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            ptr_reg     <= '0;
            ld_i_reg    <= '0;
            ld_j_reg    <= '0;
            lr_reg      <= RATE_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                lr_reg <= cfg_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (ld_go) begin
                ptr_reg <= ptr_reg + PW'(1);
                if (!in_ho && ld_j_reg == JW'(HIDDEN_COUNT - 1)) begin
                    ld_j_reg <= '0;
                    ld_i_reg <= ld_i_reg + LIW'(1);
                end else begin
                    ld_j_reg <= ld_j_reg + JW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < INPUT_COUNT; i++) begin
                x_reg[i] <= feat_ext[VAL_W*i +: VAL_W];
            end
            x_reg[INPUT_COUNT] <= $signed({3'd0, ONE_Q12});
            tgt_reg      <= s_target;
            train_reg    <= (cmd == CMD_TRAIN);
            res_load_reg <= (cmd == CMD_LOAD);
        end
        unique case (state_reg)
            ST_IDLE: cnt_reg <= '0;
            ST_FWD:  cnt_reg <= (cnt_reg == CNT_W'(INPUT_COUNT)) ? '0 : cnt_reg + CNT_W'(1);
            ST_OMAC: cnt_reg <= cnt_reg + CNT_W'(1);
            // point back at input 0 ahead of the weight updates
            ST_OSIG: cnt_reg <= '0;
            ST_UPDV: begin
                // prime the first input's scaled rate in the cycle before the lanes use it
                cnt_reg    <= CNT_W'(1);
                widx_reg   <= '0;
                scaled_reg <= scale_full[32:12];
            end
            ST_UPDW: begin
                cnt_reg    <= cnt_reg + CNT_W'(1);
                widx_reg   <= cnt_reg;
                scaled_reg <= scale_full[32:12];
            end
            default: ;
        endcase
        if (out_load) begin
            m_net_reg <= res_load_reg ? '0 : o_w;
            m_err_reg <= res_load_reg ? '0 : err_w;
            m_pos_reg <= POS_W'(ptr_reg);
        end
    end

    genvar gj;
    generate
        for (gj = 0; gj < HIDDEN_COUNT; gj++) begin : g_lane
            mlpbp_lane #(
                .INPUT_COUNT  (INPUT_COUNT),
                .WEIGHT_WIDTH (WEIGHT_WIDTH)
            ) u_lane (
                .aclk      (aclk),
                .ctrl      (lane_ctrl),
                .x_in      (x_sel),
                .go_in     (go_w),
                .lrate     (lr_reg),
                .scaled_in (scaled_reg),
                .ld_we     (lane_we[gj]),
                .ld_v      (in_ho),
                .ld_idx    (CNT_W'(ld_i_reg)),
                .ld_data   (ld_data),
                .h_out     (h_all[gj*ACT_W +: ACT_W]),
                .v_out     (v_all[gj*WW +: WW])
            );
        end
    endgenerate

    mlpbp_merge #(
        .HIDDEN_COUNT (HIDDEN_COUNT),
        .WEIGHT_WIDTH (WEIGHT_WIDTH)
    ) u_merge (
        .aclk    (aclk),
        .ctrl    (merge_ctrl),
        .h_all   (h_all),
        .v_all   (v_all),
        .target  (tgt_reg),
        .lrate   (lr_reg),
        .ld_we   (bias_we),
        .ld_data (ld_data),
        .o_out   (o_w),
        .err_out (err_w),
        .go_out  (go_w)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(TDATA_OUT_W-ACT_W-VAL_W-POS_W){1'b0}}, m_pos_reg, m_err_reg, m_net_reg};

endmodule
